// ===== src/i2c_master_byte_engine_assert.svh =====
// Assertion macros for the checker file.
// Each macro expects clk and arst_n to exist in the scope where it is used.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cm checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cm checker: next-cycle property failed");

`endif

// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

	// Byte width on the bus.
	localparam int DATA_BITS = 8;

	// Depth of the queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Command codes as they arrive on the func field.
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	// Configuration register indexes.
	localparam int         CFG_IDX_W        = 2;
	localparam logic [1:0] REG_PHASE_TICKS  = 2'd0;
	localparam logic [1:0] REG_STOP_ON_NACK = 2'd1;

	// Configuration reset values.
	localparam logic [7:0] PHASE_TICKS_RST  = 8'd5;
	localparam logic       STOP_ON_NACK_RST = 1'b1;

	// Classified command, as the front hands it to the back.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	// Bus phase sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STA1,
		ST_STA2,
		ST_STP1,
		ST_STP2,
		ST_STP3,
		ST_WLO,
		ST_WHI,
		ST_ALO,
		ST_AHI,
		ST_RLO,
		ST_RHI,
		ST_KLO,
		ST_KHI
	} step_t;

	// One queued tick.
	typedef struct packed {
		cmd_t                 cmd;
		logic [DATA_BITS-1:0] write_data;
		logic                 ack_to_send;
		logic                 sda_sample;
	} qword_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// Configuration register file.
	typedef struct packed {
		logic [7:0] phase_ticks;
		logic       stop_on_nack;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic                 scl_level;
		logic                 sda_release;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_data;
		logic                 nack_seen;
	} res_t;

endpackage

// ===== src/i2cm_if.sv =====
`timescale 1ns / 1ps

// Command tick channel.
interface i2cm_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     func;
	logic [i2cm_pkg::DATA_BITS-1:0] write_data;
	logic                           ack_to_send;
	logic                           sda_sample;

	modport source (output valid, output func, output write_data, output ack_to_send,
		output sda_sample, input ready);
	modport sink (input valid, input func, input write_data, input ack_to_send,
		input sda_sample, output ready);
endinterface

// Result word channel.
interface i2cm_res_if;
	logic                           valid;
	logic                           ready;
	logic                           scl_level;
	logic                           sda_release;
	logic                           busy_res;
	logic                           done_res;
	logic [i2cm_pkg::DATA_BITS-1:0] read_data;
	logic                           nack_seen;

	modport source (output valid, output scl_level, output sda_release, output busy_res,
		output done_res, output read_data, output nack_seen, input ready);
	modport sink (input valid, input scl_level, input sda_release, input busy_res,
		input done_res, input read_data, input nack_seen, output ready);
endinterface

// ===== src/i2cm_front.sv =====
`timescale 1ns / 1ps

module i2cm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	i2cm_cmd_if.sink              cmd,
	input  i2cm_pkg::qstat_t      qstat,
	output logic                  push,
	output i2cm_pkg::qword_t      push_word
);

	logic             valid_s1;
	i2cm_pkg::qword_t word_s1;
	i2cm_pkg::qword_t word_d;

	// Map the raw func code to a command; unknown codes act as no command.
	function automatic i2cm_pkg::cmd_t classify(input logic [2:0] func);
		i2cm_pkg::cmd_t c;
		case (func)
			i2cm_pkg::FUNC_START: c = i2cm_pkg::CMD_START;
			i2cm_pkg::FUNC_STOP:  c = i2cm_pkg::CMD_STOP;
			i2cm_pkg::FUNC_WRITE: c = i2cm_pkg::CMD_WRITE;
			i2cm_pkg::FUNC_READ:  c = i2cm_pkg::CMD_READ;
			default:              c = i2cm_pkg::CMD_NONE;
		endcase
		return c;
	endfunction

	// Build the queue word from the incoming tick.
	always_comb begin
		word_d.cmd         = classify(cmd.func);
		word_d.write_data  = cmd.write_data;
		word_d.ack_to_send = cmd.ack_to_send;
		word_d.sda_sample  = cmd.sda_sample;
	end

	// The stage is free when empty or when it drains into the queue this cycle.
	assign push      = valid_s1 && !qstat.full;
	assign cmd.ready = !valid_s1 || !qstat.full;
	assign push_word = word_s1;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			word_s1 <= word_d;
		end
	end

endmodule

// ===== src/i2cm_fifo.sv =====
`timescale 1ns / 1ps

module i2cm_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  i2cm_pkg::qword_t push_word,
	input  logic             pop,
	output i2cm_pkg::qword_t pop_word,
	output i2cm_pkg::qstat_t qstat
);

	i2cm_pkg::qword_t               mem_q [i2cm_pkg::FIFO_DEPTH];
	logic [i2cm_pkg::FIFO_AW-1:0]   wptr_q;
	logic [i2cm_pkg::FIFO_AW-1:0]   rptr_q;
	logic [i2cm_pkg::FIFO_AW:0]     count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == (i2cm_pkg::FIFO_AW + 1)'(i2cm_pkg::FIFO_DEPTH));
	assign pop_word    = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_word;
		end
	end

endmodule

// ===== src/i2cm_back.sv =====
`timescale 1ns / 1ps

module i2cm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  i2cm_pkg::cfg_t   cfg,
	input  i2cm_pkg::qstat_t qstat,
	input  i2cm_pkg::qword_t pop_word,
	output logic             pop,
	i2cm_res_if.source       res
);

	localparam int DB = i2cm_pkg::DATA_BITS;

	// Sequencer state.
	i2cm_pkg::step_t st_q, st_n;
	logic [7:0]      phase_q, phase_n;
	logic [3:0]      bit_q, bit_n;
	logic [DB-1:0]   shift_q, shift_n;
	logic            ack_q, ack_n;
	logic            scl_q, scl_n;
	logic            sda_q, sda_n;
	logic [DB-1:0]   rx_q, rx_n;
	logic            nack_q, nack_n;

	// Output register.
	logic            res_valid_q;
	i2cm_pkg::res_t  res_q;

	logic            done;
	logic            go;
	i2cm_pkg::step_t go_st;
	logic [7:0]      limit;
	logic [7:0]      phase_inc;

	// Take a tick whenever the output register is free or being drained.
	assign pop = !qstat.empty && (!res_valid_q || res.ready);

	assign limit     = (cfg.phase_ticks == '0) ? 8'd1 : cfg.phase_ticks;
	assign phase_inc = phase_q + 8'd1;

	// One tick of the phase sequencer.
	always_comb begin
		st_n    = st_q;
		phase_n = phase_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		ack_n   = ack_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rx_n    = rx_q;
		nack_n  = nack_q;
		done    = 1'b0;
		go      = 1'b0;
		go_st   = i2cm_pkg::ST_IDLE;

		if (st_q == i2cm_pkg::ST_IDLE) begin
			// Idle: start a new command.
			bit_n = '0;
			case (pop_word.cmd)
				i2cm_pkg::CMD_START: begin
					go    = 1'b1;
					go_st = i2cm_pkg::ST_STA1;
				end
				i2cm_pkg::CMD_STOP: begin
					go    = 1'b1;
					go_st = i2cm_pkg::ST_STP1;
				end
				i2cm_pkg::CMD_WRITE: begin
					shift_n = pop_word.write_data;
					go      = 1'b1;
					go_st   = i2cm_pkg::ST_WLO;
				end
				i2cm_pkg::CMD_READ: begin
					shift_n = '0;
					ack_n   = pop_word.ack_to_send;
					go      = 1'b1;
					go_st   = i2cm_pkg::ST_RLO;
				end
				default: ;
			endcase
		end else begin
			// Busy: count the phase and move on when it has run its length.
			phase_n = phase_inc;
			if (phase_inc >= limit) begin
				case (st_q)
					i2cm_pkg::ST_STA1: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_STA2;
					end
					i2cm_pkg::ST_STA2: begin
						scl_n = 1'b0;
						st_n  = i2cm_pkg::ST_IDLE;
						done  = 1'b1;
					end
					i2cm_pkg::ST_STP1: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_STP2;
					end
					i2cm_pkg::ST_STP2: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_STP3;
					end
					i2cm_pkg::ST_STP3: begin
						st_n = i2cm_pkg::ST_IDLE;
						done = 1'b1;
					end
					i2cm_pkg::ST_WLO: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_WHI;
					end
					i2cm_pkg::ST_WHI: begin
						shift_n = {shift_q[DB-2:0], 1'b0};
						bit_n   = bit_q + 4'd1;
						go      = 1'b1;
						go_st   = (bit_n >= 4'(DB)) ? i2cm_pkg::ST_ALO : i2cm_pkg::ST_WLO;
					end
					i2cm_pkg::ST_ALO: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_AHI;
					end
					i2cm_pkg::ST_AHI: begin
						// The acknowledge is sampled once, at the end of its high phase.
						nack_n = pop_word.sda_sample;
						if (pop_word.sda_sample && cfg.stop_on_nack) begin
							go    = 1'b1;
							go_st = i2cm_pkg::ST_STP1;
						end else begin
							scl_n = 1'b0;
							st_n  = i2cm_pkg::ST_IDLE;
							done  = 1'b1;
						end
					end
					i2cm_pkg::ST_RLO: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_RHI;
					end
					i2cm_pkg::ST_RHI: begin
						shift_n = {shift_q[DB-2:0], pop_word.sda_sample};
						bit_n   = bit_q + 4'd1;
						go      = 1'b1;
						if (bit_n >= 4'(DB)) begin
							rx_n  = shift_n;
							go_st = i2cm_pkg::ST_KLO;
						end else begin
							go_st = i2cm_pkg::ST_RLO;
						end
					end
					i2cm_pkg::ST_KLO: begin
						go    = 1'b1;
						go_st = i2cm_pkg::ST_KHI;
					end
					i2cm_pkg::ST_KHI: begin
						scl_n = 1'b0;
						st_n  = i2cm_pkg::ST_IDLE;
						done  = 1'b1;
					end
					default: begin
						st_n = i2cm_pkg::ST_IDLE;
					end
				endcase
			end
		end

		// Entering a phase sets its line levels and restarts the phase count.
		if (go) begin
			st_n    = go_st;
			phase_n = '0;
			case (go_st)
				i2cm_pkg::ST_STA1: begin scl_n = 1'b1; sda_n = 1'b1; end
				i2cm_pkg::ST_STA2: begin scl_n = 1'b1; sda_n = 1'b0; end
				i2cm_pkg::ST_STP1: begin scl_n = 1'b0; sda_n = 1'b0; end
				i2cm_pkg::ST_STP2: begin scl_n = 1'b1; sda_n = 1'b0; end
				i2cm_pkg::ST_STP3: begin scl_n = 1'b1; sda_n = 1'b1; end
				i2cm_pkg::ST_WLO:  begin scl_n = 1'b0; sda_n = shift_n[DB-1]; end
				i2cm_pkg::ST_WHI:  begin scl_n = 1'b1; end
				i2cm_pkg::ST_ALO:  begin scl_n = 1'b0; sda_n = 1'b1; end
				i2cm_pkg::ST_AHI:  begin scl_n = 1'b1; sda_n = 1'b1; end
				i2cm_pkg::ST_RLO:  begin scl_n = 1'b0; sda_n = 1'b1; end
				i2cm_pkg::ST_RHI:  begin scl_n = 1'b1; sda_n = 1'b1; end
				i2cm_pkg::ST_KLO:  begin scl_n = 1'b0; sda_n = ack_n; end
				i2cm_pkg::ST_KHI:  begin scl_n = 1'b1; end
				default:           st_n = i2cm_pkg::ST_IDLE;
			endcase
		end
	end

	// Sequencer registers advance once per taken tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= i2cm_pkg::ST_IDLE;
			phase_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rx_q    <= '0;
			nack_q  <= 1'b0;
		end else if (pop) begin
			st_q    <= st_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rx_q    <= rx_n;
			nack_q  <= nack_n;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl_level   <= scl_n;
			res_q.sda_release <= sda_n;
			res_q.busy_res    <= (st_n != i2cm_pkg::ST_IDLE);
			res_q.done_res    <= done;
			res_q.read_data   <= rx_n;
			res_q.nack_seen   <= nack_n;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.scl_level   = res_q.scl_level;
	assign res.sda_release = res_q.sda_release;
	assign res.busy_res    = res_q.busy_res;
	assign res.done_res    = res_q.done_res;
	assign res.read_data   = res_q.read_data;
	assign res.nack_seen   = res_q.nack_seen;

endmodule

// ===== src/i2c_master_byte_engine.sv =====
// Throughput: one command word per clock while the queue has room, one result
// word per command word. A result word passes the front stage register, the
// queue, then the sequencer step into the output register.
// A four-word queue lets the command side keep running while results stall.
// Reset (arst_n low) idles the sequencer, releases SCL and SDA, clears the
// received byte and NACK flag, and loads phase_ticks 5 and stop_on_nack 1.
`timescale 1ns / 1ps

module i2c_master_byte_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [7:0]                          cfg_wdata,
	i2cm_cmd_if.sink                            cmd,
	i2cm_res_if.source                          res
);

	i2cm_pkg::cfg_t   cfg_q;
	i2cm_pkg::qstat_t qstat;
	i2cm_pkg::qword_t push_word;
	i2cm_pkg::qword_t pop_word;
	logic             push;
	logic             pop;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks  <= i2cm_pkg::PHASE_TICKS_RST;
			cfg_q.stop_on_nack <= i2cm_pkg::STOP_ON_NACK_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				i2cm_pkg::REG_PHASE_TICKS:  cfg_q.phase_ticks  <= cfg_wdata;
				i2cm_pkg::REG_STOP_ON_NACK: cfg_q.stop_on_nack <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Front: take and classify command words.
	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	// Queue between front and back.
	i2cm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.qstat     (qstat)
	);

	// Back: bus phase sequencer and result register.
	i2cm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.pop_word (pop_word),
		.pop      (pop),
		.res      (res)
	);

endmodule

// ===== src/i2cm_checker.sv =====
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_assert.svh"

module i2cm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic                           res_busy_res,
	input logic                           res_done_res,
	input logic [i2cm_pkg::DATA_BITS-1:0] res_read_data
);

	// A stalled result word stays offered.
	`I2CM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

	// A stalled result word keeps its received byte.
	`I2CM_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_read_data))

	// A command that finishes leaves the engine idle in the same word.
	`I2CM_ASSERT_SAME(a_done_idle, res_valid && res_done_res, !res_busy_res)

	// With no result waiting the queue cannot be full, so commands are taken.
	`I2CM_ASSERT_SAME(a_ready_when_drained, !res_valid, cmd_ready)

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_busy_res  (res.busy_res),
	.res_done_res  (res.done_res),
	.res_read_data (res.read_data)
);
